[src/utf8d_pkg.sv]
// Shared types and constants for the UTF-8 stream decoder.
package utf8d_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned CpW   = 21;
    localparam int unsigned LenW  = 3;

    // Surrogate range of code points
    localparam logic [CpW-1:0] SurrLo = 21'h00D800;
    localparam logic [CpW-1:0] SurrHi = 21'h00DFFF;

    // Lead byte payload masks
    localparam logic [ByteW-1:0] Lead2Mask = 8'h1F;
    localparam logic [ByteW-1:0] Lead3Mask = 8'h0F;
    localparam logic [ByteW-1:0] Lead4Mask = 8'h07;
    localparam logic [ByteW-1:0] ContMask  = 8'h3F;

    // Sequence lengths
    localparam logic [LenW-1:0] Len0 = 3'd0;
    localparam logic [LenW-1:0] Len1 = 3'd1;
    localparam logic [LenW-1:0] Len2 = 3'd2;
    localparam logic [LenW-1:0] Len3 = 3'd3;
    localparam logic [LenW-1:0] Len4 = 3'd4;

    // Open-sequence state carried between bytes
    typedef struct packed {
        logic [CpW-1:0]  partial;
        logic [LenW-1:0] expected;
        logic [LenW-1:0] held;
    } seq_state_t;

    // Result burst for one input byte: count results, all errors except a
    // good final one when final_ok is set
    typedef struct packed {
        logic [LenW-1:0] count;
        logic            final_ok;
        logic [CpW-1:0]  codepoint;
        logic [LenW-1:0] seq_length;
    } burst_t;

endpackage

[src/utf8_stream_decoder.sv]
// Top level of the UTF-8 stream decoder: handshake, state and result burst.
//
// Usage:
//   Input stream (s_*): one UTF-8 byte per transfer in s_tdata, s_tlast set
//   on the last byte of the data. Output stream (m_*): one decoded result per
//   transfer; m_tdata carries code point and length, m_tuser the error flag,
//   m_tlast marks the last result caused by one input byte.
//   A byte is decoded in the cycle it is taken and its results sit in the
//   output register from the next cycle.
//   While the receiver takes every result, a clean stream runs at one byte
//   per cycle. A byte that yields N results (up to 4, for error flushes)
//   holds the output register for N transfers; the next byte is taken in
//   the cycle the last of them is taken.
//   Bytes that only extend an open sequence give no result and do not stall.
//   When the receiver stalls, the pending result holds; while results are
//   pending, s_tready is high only while the last of the burst is taken.
//   Reset closes any open sequence and empties the output register.
module utf8_stream_decoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // end_of_data
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [20:0] codepoint, [23:21] seq_length
    output logic        m_tuser,   // [0] error
    output logic        m_tlast    // run_last
);

    utf8d_pkg::seq_state_t         state_reg;
    utf8d_pkg::seq_state_t         state_next;
    utf8d_pkg::burst_t             burst_next;
    logic [utf8d_pkg::LenW-1:0]    count_reg;
    logic                          final_ok_reg;
    logic [utf8d_pkg::CpW-1:0]     codepoint_reg;
    logic [utf8d_pkg::LenW-1:0]    seq_length_reg;
    logic                          in_xfer;
    logic                          out_xfer;
    logic                          on_final;
    logic                          good_out;

    utf8d_decode u_decode
    (
        .in_byte     (s_tdata),
        .end_of_data (s_tlast),
        .state       (state_reg),
        .state_next  (state_next),
        .burst       (burst_next)
    );

    // Handshake
    assign on_final = (count_reg == utf8d_pkg::Len1);
    assign m_tvalid = (count_reg != utf8d_pkg::Len0);
    assign s_tready = (count_reg == utf8d_pkg::Len0) || (on_final && m_tready);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_xfer = m_tvalid && m_tready;

    // Present errors first, then the good result if there is one
    assign good_out = on_final && final_ok_reg;
    assign m_tdata  = good_out ? {seq_length_reg, codepoint_reg}
                               : {utf8d_pkg::Len1, {utf8d_pkg::CpW{1'b0}}};
    assign m_tuser  = !good_out;
    assign m_tlast  = on_final;

    // Advance sequence state and result count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
            count_reg <= utf8d_pkg::Len0;
        end
        else if (in_xfer)
        begin
            state_reg <= state_next;
            count_reg <= burst_next.count;
        end
        else if (out_xfer)
        begin
            count_reg <= count_reg - utf8d_pkg::Len1;
        end
    end

    // Load result payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            final_ok_reg   <= burst_next.final_ok;
            codepoint_reg  <= burst_next.codepoint;
            seq_length_reg <= burst_next.seq_length;
        end
    end

endmodule

[src/utf8d_decode.sv]
// Combinational decode of one byte against the open-sequence state.
module utf8d_decode
(
    input  logic [utf8d_pkg::ByteW-1:0] in_byte,
    input  logic                        end_of_data,
    input  utf8d_pkg::seq_state_t       state,
    output utf8d_pkg::seq_state_t       state_next,
    output utf8d_pkg::burst_t           burst
);

    logic                          is_cont;
    logic                          is_lead2;
    logic                          is_lead3;
    logic                          is_lead4;
    logic                          do_lead;
    logic [utf8d_pkg::LenW-1:0]    err_pre;
    logic [utf8d_pkg::CpW-1:0]     partial_shift;
    logic [utf8d_pkg::LenW-1:0]    held_inc;
    logic                          surrogate;

    assign is_cont  = (in_byte[7:6] == 2'b10);
    assign is_lead2 = (in_byte[7:5] == 3'b110);
    assign is_lead3 = (in_byte[7:4] == 4'b1110);
    assign is_lead4 = (in_byte[7:3] == 5'b11110);

    assign partial_shift = {state.partial[utf8d_pkg::CpW-7:0],
                            in_byte[5:0] & utf8d_pkg::ContMask[5:0]};
    assign held_inc      = state.held + utf8d_pkg::Len1;
    assign surrogate     = (partial_shift >= utf8d_pkg::SurrLo) &&
                           (partial_shift <= utf8d_pkg::SurrHi);

    // Resolve the byte: continue, close, flush, then treat as a lead
    always_comb
    begin
        state_next       = state;
        burst.count      = utf8d_pkg::Len0;
        burst.final_ok   = 1'b0;
        burst.codepoint  = '0;
        burst.seq_length = utf8d_pkg::Len1;
        do_lead          = 1'b1;
        err_pre          = utf8d_pkg::Len0;

        if (state.expected != utf8d_pkg::Len0)
        begin
            if (is_cont)
            begin
                do_lead = 1'b0;
                if (held_inc >= state.expected)
                begin
                    // Sequence complete
                    if (surrogate)
                    begin
                        burst.count = held_inc;
                    end
                    else
                    begin
                        burst.count      = utf8d_pkg::Len1;
                        burst.final_ok   = 1'b1;
                        burst.codepoint  = partial_shift;
                        burst.seq_length = state.expected;
                    end
                    state_next = '0;
                end
                else if (end_of_data)
                begin
                    // Cut off by end of data: flush every held byte
                    burst.count = held_inc;
                    state_next  = '0;
                end
                else
                begin
                    state_next.partial = partial_shift;
                    state_next.held    = held_inc;
                end
            end
            else
            begin
                // Missing continuation: flush held bytes, then decode anew
                err_pre    = state.held;
                state_next = '0;
            end
        end

        if (do_lead)
        begin
            priority if (!in_byte[7])
            begin
                burst.count      = err_pre + utf8d_pkg::Len1;
                burst.final_ok   = 1'b1;
                burst.codepoint  = {{(utf8d_pkg::CpW-utf8d_pkg::ByteW){1'b0}}, in_byte};
                burst.seq_length = utf8d_pkg::Len1;
            end
            else if ((is_lead2 || is_lead3 || is_lead4) && !end_of_data)
            begin
                // Open a new sequence
                burst.count = err_pre;
                state_next.held = utf8d_pkg::Len1;
                if (is_lead2)
                begin
                    state_next.expected = utf8d_pkg::Len2;
                    state_next.partial  = {{(utf8d_pkg::CpW-utf8d_pkg::ByteW){1'b0}},
                                           in_byte & utf8d_pkg::Lead2Mask};
                end
                else if (is_lead3)
                begin
                    state_next.expected = utf8d_pkg::Len3;
                    state_next.partial  = {{(utf8d_pkg::CpW-utf8d_pkg::ByteW){1'b0}},
                                           in_byte & utf8d_pkg::Lead3Mask};
                end
                else
                begin
                    state_next.expected = utf8d_pkg::Len4;
                    state_next.partial  = {{(utf8d_pkg::CpW-utf8d_pkg::ByteW){1'b0}},
                                           in_byte & utf8d_pkg::Lead4Mask};
                end
            end
            else
            begin
                // Bad lead, stray continuation, or lead at end of data
                burst.count = err_pre + utf8d_pkg::Len1;
            end
        end
    end

endmodule
